### rtl/core/fcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared types, widths and the quarter-wave sine table for the FMCW chirp
// generator.
// ----------------------------------------------------------------------------
package fcg_pkg;

  // Datapath widths
  localparam int unsigned PHASE_BITS  = 10;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FREQ_BITS   = 32;
  localparam int unsigned QTR_BITS    = PHASE_BITS - 2;
  localparam int unsigned QTR_SIZE    = 1 << QTR_BITS;
  localparam int unsigned MAG_W       = SAMPLE_BITS - 1;
  localparam int unsigned AMP_W       = 15;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned PROD_W      = MAG_W + AMP_W;
  localparam int unsigned QUO_W       = 15;
  localparam int unsigned REM_W       = QUO_W + 2;

  // Fixed-point constants
  localparam int unsigned Q30         = 30;
  localparam longint unsigned SMAX    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam int unsigned AMP_FULL    = 32767;
  localparam int unsigned AMP_HALF    = 16383;

  // Register reset values
  localparam logic [AMP_W-1:0]     AMP_RST       = 15'd32767;
  localparam logic [FREQ_BITS-1:0] START_RST     = 32'd42949673;
  localparam logic [FREQ_BITS-1:0] UP_STEP_RST   = 32'd214748;
  localparam logic [FREQ_BITS-1:0] DOWN_STEP_RST = 32'd214748;
  localparam logic [LEN_W-1:0]     UP_LEN_RST    = 32'd100;
  localparam logic [LEN_W-1:0]     FIX_LEN_RST   = 32'd0;
  localparam logic [LEN_W-1:0]     DOWN_LEN_RST  = 32'd0;
  localparam logic [LEN_W-1:0]     OFF_LEN_RST   = 32'd0;

  // Sweep segments
  typedef enum logic [1:0] {
    SEG_UP   = 2'd0,
    SEG_HOLD = 2'd1,
    SEG_DOWN = 2'd2,
    SEG_OFF  = 2'd3
  } seg_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE  = 3'd0,
    CFG_START_FREQ = 3'd1,
    CFG_UP_STEP    = 3'd2,
    CFG_DOWN_STEP  = 3'd3,
    CFG_UP_LEN     = 3'd4,
    CFG_FIX_LEN    = 3'd5,
    CFG_DOWN_LEN   = 3'd6,
    CFG_OFF_LEN    = 3'd7
  } cfg_idx_e;

  // Quarter-wave magnitudes, one extra entry for the peak
  typedef logic [MAG_W-1:0] qtab_t [QTR_SIZE+1];

  // sin(pi/2 * x) in Q30, degree 9 odd polynomial
  function automatic logic [63:0] quarter_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    x2 = (x * x) >> Q30;
    p  = 64'd172271;
    p  = 64'd5026991    - ((x2 * p) >> Q30);
    p  = 64'd85569298   - ((x2 * p) >> Q30);
    p  = 64'd693598669  - ((x2 * p) >> Q30);
    p  = 64'd1686629713 - ((x2 * p) >> Q30);
    return (x * p) >> Q30;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t       t;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    for (int n = 0; n <= int'(QTR_SIZE); n++) begin
      x = 64'(n) << (Q30 - QTR_BITS);
      s = quarter_sin(x);
      v = (s * SMAX + (64'd1 << (Q30 - 1))) >> Q30;
      if (v > SMAX) begin
        v = SMAX;
      end
      t[n] = v[MAG_W-1:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

### rtl/core/fmcw_chirp_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcw_chirp_generator
// FMCW chirp NCO: four-segment frequency sweep (up, hold, down, off) driving a
// phase accumulator and a quarter-wave sine table scaled by amplitude.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                                       Transfer when
//  cfg      in   cfg_we_i cfg_index_i cfg_data_i               cfg_we_i high
//  in       in   in_valid_i in_ready_o restart_i               valid & ready
//  out      out  out_valid_o out_ready_i i/q_sample freq seg   valid & ready
//
//  One sample per clock unless the output stalls; out_valid_o rises once a
//  sample is in stage 3. The sweep state (segment, position, frequency, phase)
//  updates in the input transfer cycle, so each item follows the next at once.
//  Table lookup plus amplitude multiply, then the divide by full scale, each
//  take one register stage. Reset loads the register defaults and the start
//  of the up ramp; no clearing pass. A stalled output back-pressures the
//  pipe stage by stage; in_ready_o drops only when all three stages are full.
// ----------------------------------------------------------------------------
module fmcw_chirp_generator
  import fcg_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]            cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [OUT_W-1:0]     i_sample_o,
  output logic signed [OUT_W-1:0]     q_sample_o,
  output logic [FREQ_BITS-1:0]        freq_word_o,
  output logic [1:0]                  segment_o
);

  // Configuration registers
  logic [AMP_W-1:0]     amp_q;
  logic [FREQ_BITS-1:0] start_freq_q, up_step_q, down_step_q;
  logic [LEN_W-1:0]     up_len_q, fix_len_q, down_len_q, off_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q        <= AMP_RST;
      start_freq_q <= START_RST;
      up_step_q    <= UP_STEP_RST;
      down_step_q  <= DOWN_STEP_RST;
      up_len_q     <= UP_LEN_RST;
      fix_len_q    <= FIX_LEN_RST;
      down_len_q   <= DOWN_LEN_RST;
      off_len_q    <= OFF_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_AMPLITUDE:  amp_q        <= cfg_data_i[AMP_W-1:0];
        CFG_START_FREQ: start_freq_q <= cfg_data_i[FREQ_BITS-1:0];
        CFG_UP_STEP:    up_step_q    <= cfg_data_i[FREQ_BITS-1:0];
        CFG_DOWN_STEP:  down_step_q  <= cfg_data_i[FREQ_BITS-1:0];
        CFG_UP_LEN:     up_len_q     <= cfg_data_i[LEN_W-1:0];
        CFG_FIX_LEN:    fix_len_q    <= cfg_data_i[LEN_W-1:0];
        CFG_DOWN_LEN:   down_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_OFF_LEN:    off_len_q    <= cfg_data_i[LEN_W-1:0];
        default:        amp_q        <= amp_q;
      endcase
    end
  end

  // Pipeline handshake
  logic v1_q, v2_q, v3_q;
  logic rdy2, rdy3, in_xfer;

  assign rdy3        = !v3_q || out_ready_i;
  assign rdy2        = !v2_q || rdy3;
  assign in_ready_o  = !v1_q || rdy2;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = v3_q;

  // Sweep state
  seg_e                 seg_q, seg_d;
  logic [LEN_W-1:0]     pos_q, pos_d;
  logic [FREQ_BITS-1:0] cf_q, cf_d;
  logic [FREQ_BITS-1:0] ph_q, ph_d;

  // Segment selection and next state
  seg_e                 s0, s_sel;
  logic [LEN_W-1:0]     p0, cur_len;
  logic [FREQ_BITS-1:0] ph0, cf0, cf_sel, f_out;
  logic [3:0]           nz;
  logic                 cur_ok, found, ok, active;
  logic [2:0]           kmin, kuse, ssum;

  always_comb begin
    s0  = restart_i ? SEG_UP : seg_q;
    p0  = restart_i ? '0 : pos_q;
    ph0 = restart_i ? '0 : ph_q;
    cf0 = (s0 == SEG_UP && p0 == '0) ? start_freq_q : cf_q;

    nz = {off_len_q != '0, down_len_q != '0, fix_len_q != '0, up_len_q != '0};
    case (s0)
      SEG_UP:   cur_len = up_len_q;
      SEG_HOLD: cur_len = fix_len_q;
      SEG_DOWN: cur_len = down_len_q;
      SEG_OFF:  cur_len = off_len_q;
      default:  cur_len = up_len_q;
    endcase
    cur_ok = (cur_len != '0) && (p0 < cur_len);

    // first nonempty segment after the current one
    kmin  = 3'd4;
    found = 1'b0;
    for (int k = 4; k >= 1; k--) begin
      if (nz[2'(s0 + 2'(k))]) begin
        kmin  = 3'(k);
        found = 1'b1;
      end
    end
    kuse = kmin;
    ok   = cur_ok || found;
    ssum = {1'b0, s0} + kuse;

    if (cur_ok) begin
      s_sel  = s0;
      cf_sel = cf0;
      pos_d  = p0 + LEN_W'(1);
    end else begin
      s_sel  = seg_e'(ssum[1:0]);
      cf_sel = ssum[2] ? start_freq_q : cf0;
      pos_d  = ok ? LEN_W'(1) : '0;
    end

    active = ok && (s_sel != SEG_OFF);
    seg_d  = s_sel;
    f_out  = active ? cf_sel : '0;
    ph_d   = active ? ph0 + cf_sel : ph0;
    cf_d   = cf_sel;
    if (active && s_sel == SEG_UP) begin
      cf_d = cf_sel + up_step_q;
    end else if (active && s_sel == SEG_DOWN) begin
      cf_d = cf_sel - down_step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEG_UP;
      pos_q <= '0;
      cf_q  <= START_RST;
      ph_q  <= '0;
    end else if (in_xfer) begin
      seg_q <= seg_d;
      pos_q <= pos_d;
      cf_q  <= cf_d;
      ph_q  <= ph_d;
    end
  end

  // Stage 1: phase index and sample tags
  logic [PHASE_BITS-1:0] idx1_q;
  logic                  zero1_q;
  logic [FREQ_BITS-1:0]  f1_q;
  logic [1:0]            seg1_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx1_q  <= ph0[FREQ_BITS-1 -: PHASE_BITS];
      zero1_q <= !active;
      f1_q    <= f_out;
      seg1_q  <= ok ? s_sel : SEG_OFF;
    end
  end

  // Stage 2: table lookup and amplitude multiply
  logic [PHASE_BITS-1:0] cidx;
  logic [QTR_BITS:0]     snum, cnum;
  logic [MAG_W-1:0]      smag, cmag;
  logic [PROD_W-1:0]     sprod2_q, cprod2_q;
  logic                  sneg2_q, cneg2_q, zero2_q;
  logic [FREQ_BITS-1:0]  f2_q;
  logic [1:0]            seg2_q;

  always_comb begin
    cidx = PHASE_BITS'(idx1_q + PHASE_BITS'(QTR_SIZE));
    snum = idx1_q[QTR_BITS] ? (QTR_BITS+1)'(QTR_SIZE) - {1'b0, idx1_q[QTR_BITS-1:0]}
                            : {1'b0, idx1_q[QTR_BITS-1:0]};
    cnum = cidx[QTR_BITS]   ? (QTR_BITS+1)'(QTR_SIZE) - {1'b0, cidx[QTR_BITS-1:0]}
                            : {1'b0, cidx[QTR_BITS-1:0]};
    smag = QTAB[snum];
    cmag = QTAB[cnum];
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sprod2_q <= PROD_W'(smag) * PROD_W'(amp_q);
      cprod2_q <= PROD_W'(cmag) * PROD_W'(amp_q);
      sneg2_q  <= idx1_q[PHASE_BITS-1];
      cneg2_q  <= cidx[PHASE_BITS-1];
      zero2_q  <= zero1_q;
      f2_q     <= f1_q;
      seg2_q   <= seg1_q;
    end
  end

  // Stage 3: rounded divide by full scale, n < 2^30 so one correction step
  logic [PROD_W-1:0] sn, cn;
  logic [REM_W-1:0]  srem, crem;
  logic [QUO_W-1:0]  squo, cquo;
  logic [OUT_W-1:0]  sval, cval;

  always_comb begin
    sn   = sprod2_q + PROD_W'(AMP_HALF);
    cn   = cprod2_q + PROD_W'(AMP_HALF);
    srem = REM_W'(sn[QUO_W-1:0]) + REM_W'(sn[PROD_W-1:QUO_W]);
    crem = REM_W'(cn[QUO_W-1:0]) + REM_W'(cn[PROD_W-1:QUO_W]);
    squo = sn[PROD_W-1:QUO_W] + QUO_W'(srem >= REM_W'(AMP_FULL));
    cquo = cn[PROD_W-1:QUO_W] + QUO_W'(crem >= REM_W'(AMP_FULL));
    sval = sneg2_q ? -OUT_W'(squo) : OUT_W'(squo);
    cval = cneg2_q ? -OUT_W'(cquo) : OUT_W'(cquo);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      q_sample_o  <= zero2_q ? '0 : sval;
      i_sample_o  <= zero2_q ? '0 : cval;
      freq_word_o <= f2_q;
      segment_o   <= seg2_q;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) v1_q <= in_valid_i;
      if (rdy2)       v2_q <= v1_q;
      if (rdy3)       v3_q <= v2_q;
    end
  end

`ifndef SYNTHESIS
  // Off segment output is silent
  a_off_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && segment_o == SEG_OFF |->
      i_sample_o == '0 && q_sample_o == '0 && freq_word_o == '0)
    else $error("off segment output not zero");

  // Restart with a live up ramp starts the ramp from start_freq
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && restart_i && up_len_q != '0 |=>
      seg_q == SEG_UP && pos_q == LEN_W'(1) &&
      cf_q == FREQ_BITS'($past(start_freq_q) + $past(up_step_q)))
    else $error("restart did not reload ramp start");

  // No segment can run: position clears, frequency reloads, phase holds
  a_all_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && nz == 4'b0000 |=>
      pos_q == '0 && cf_q == $past(start_freq_q) && ph_q == $past(ph0))
    else $error("empty sweep changed state");

  // Hold keeps its frequency while phase advances by it
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && ok && s_sel == SEG_HOLD |=>
      cf_q == $past(cf_sel) && ph_q == FREQ_BITS'($past(ph0) + $past(cf_sel)))
    else $error("hold segment frequency moved");
`endif

endmodule
